### rtl/core/md4bh_pkg.sv
// ----------------------------------------------------------------------------
// md4bh_pkg
// constants, types and round helper functions of the md4 block hash unit
// ----------------------------------------------------------------------------
package md4bh_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int WADDR_W      = $clog2(BLOCK_WORDS);
    localparam int ROUNDS       = 48;
    localparam int RND_W        = $clog2(ROUNDS);
    localparam int DIGEST_WORDS = 4;
    localparam int DIDX_W       = $clog2(DIGEST_WORDS);

    localparam logic [WORD_W-1:0] IV_A    = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B    = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] IV_C    = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] IV_D    = 32'h10325476;
    localparam logic [WORD_W-1:0] K_TWO   = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_THREE = 32'h6ED9EBA1;

    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } work_t;

    // buffer slot that a round reads
    function automatic logic [WADDR_W-1:0] msg_index(input logic [RND_W-1:0] rnd);
        logic [3:0] i;
        begin
            i = rnd[3:0];
            case (rnd[5:4])
                GRP_F:   msg_index = i;
                GRP_G:   msg_index = {i[1:0], i[3:2]};
                GRP_H:   msg_index = {i[0], i[1], i[2], i[3]};
                default: msg_index = '0;
            endcase
        end
    endfunction

    function automatic logic [4:0] round_shift(input logic [RND_W-1:0] rnd);
        logic [1:0] j;
        begin
            j = rnd[1:0];
            case (rnd[5:4])
                GRP_F:
                begin
                    case (j)
                        2'd0:    round_shift = 5'd3;
                        2'd1:    round_shift = 5'd7;
                        2'd2:    round_shift = 5'd11;
                        default: round_shift = 5'd19;
                    endcase
                end
                GRP_G:
                begin
                    case (j)
                        2'd0:    round_shift = 5'd3;
                        2'd1:    round_shift = 5'd5;
                        2'd2:    round_shift = 5'd9;
                        default: round_shift = 5'd13;
                    endcase
                end
                default:
                begin
                    case (j)
                        2'd0:    round_shift = 5'd3;
                        2'd1:    round_shift = 5'd9;
                        2'd2:    round_shift = 5'd11;
                        default: round_shift = 5'd15;
                    endcase
                end
            endcase
        end
    endfunction

    function automatic logic [WORD_W-1:0] round_const(input logic [RND_W-1:0] rnd);
        begin
            case (rnd[5:4])
                GRP_F:   round_const = '0;
                GRP_G:   round_const = K_TWO;
                default: round_const = K_THREE;
            endcase
        end
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [4:0] s);
        logic [2*WORD_W-1:0] t;
        begin
            t    = {{WORD_W{1'b0}}, v} << s;
            rotl = t[2*WORD_W-1:WORD_W] | t[WORD_W-1:0];
        end
    endfunction

endpackage

### rtl/core/md4bh_round.sv
// ----------------------------------------------------------------------------
// md4bh_round
// one md4 round: boolean mix, four-term add, rotate and register rotation
// ----------------------------------------------------------------------------
module md4bh_round
    import md4bh_pkg::*;
(
    input  logic [RND_W-1:0]  rnd,
    input  work_t             cur,
    input  logic [WORD_W-1:0] w,
    output work_t             nxt
);

    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] sum;

    always_comb
    begin
        case (rnd[5:4])
            GRP_F:   f = (cur.b & cur.c) | (~cur.b & cur.d);
            GRP_G:   f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            default: f = cur.b ^ cur.c ^ cur.d;
        endcase
    end

    assign sum = cur.a + f + w + round_const(rnd);

    // target moves a, d, c, b: rotate the names instead of the data path
    always_comb
    begin
        nxt.a = cur.d;
        nxt.b = rotl(sum, round_shift(rnd));
        nxt.c = cur.b;
        nxt.d = cur.c;
    end

endmodule

### rtl/core/md4_block_hash_unit.sv
// the first digest word is registered by the ST_FIN chain update that follows the compression
// rounds after the transfer of the final 16th word; they run one per cycle on the shared
//   round unit fed by the buffer read port
// words are not taken during compression; digest words drain while the next block loads
// reset clears control and loads the md4 initial values; the block buffer is undefined
// ----------------------------------------------------------------------------
// md4_block_hash_unit
// md4 compression over host-padded 32-bit words, emits digest a, b, c, d
// ----------------------------------------------------------------------------
module md4_block_hash_unit
    import md4bh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   message_word,
    input  logic                start_message,
    input  logic                final_block,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   digest_word,
    output logic [DIDX_W-1:0]   digest_index,
    output logic                last_digest_word
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_COMP = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [WADDR_W-1:0] wcount_reg, wcount_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic               final_reg, final_next;
    work_t              chain_reg, chain_next;
    work_t              work_reg, work_next;
    work_t              round_out;

    logic [WORD_W-1:0]  buf_mem [BLOCK_WORDS];
    logic [WADDR_W-1:0] wr_addr;
    logic [WADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_data_reg;
    logic               in_xfer;
    logic               out_xfer;
    logic               snap;

    logic [WORD_W-1:0]  dig_reg [DIGEST_WORDS];
    logic               out_valid_reg, out_valid_next;
    logic [DIDX_W-1:0]  didx_reg, didx_next;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_xfer  = in_valid & in_ready;
    assign out_xfer = out_valid_reg & out_ready;
    assign wr_addr  = start_message ? '0 : wcount_reg;

    // while loading, keep slot zero on the read port so round zero finds it
    assign rd_addr = (state_reg == ST_COMP) ? msg_index(rnd_reg + 1'b1) : msg_index('0);

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            buf_mem[wr_addr] <= message_word;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    md4bh_round u_round (
        .rnd (rnd_reg),
        .cur (work_reg),
        .w   (rd_data_reg),
        .nxt (round_out)
    );

    // final block waits here while an earlier digest still drains
    assign snap = (state_reg == ST_FIN) && final_reg && !out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        wcount_next = wcount_reg;
        rnd_next    = rnd_reg;
        final_next  = final_reg;
        chain_next  = chain_reg;
        work_next   = work_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (start_message)
                    begin
                        chain_next = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
                    end
                    wcount_next = wr_addr + 1'b1;
                    if (wr_addr == WADDR_W'(BLOCK_WORDS - 1))
                    begin
                        final_next = final_block;
                        work_next  = start_message ?
                                     '{a: IV_A, b: IV_B, c: IV_C, d: IV_D} : chain_reg;
                        rnd_next   = '0;
                        state_next = ST_COMP;
                    end
                end
            end
            ST_COMP:
            begin
                work_next = round_out;
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!final_reg || !out_valid_reg)
                begin
                    chain_next.a = chain_reg.a + work_reg.a;
                    chain_next.b = chain_reg.b + work_reg.b;
                    chain_next.c = chain_reg.c + work_reg.c;
                    chain_next.d = chain_reg.d + work_reg.d;
                    state_next   = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        didx_next      = didx_reg;
        if (snap)
        begin
            out_valid_next = 1'b1;
            didx_next      = '0;
        end
        else if (out_xfer)
        begin
            didx_next = didx_reg + 1'b1;
            if (didx_reg == DIDX_W'(DIGEST_WORDS - 1))
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            wcount_reg    <= '0;
            rnd_reg       <= '0;
            final_reg     <= 1'b0;
            chain_reg     <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            out_valid_reg <= 1'b0;
            didx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wcount_reg    <= wcount_next;
            rnd_reg       <= rnd_next;
            final_reg     <= final_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
            didx_reg      <= didx_next;
        end
    end

    // digest words shift toward slot zero on each output transfer
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (snap)
        begin
            dig_reg[0] <= chain_next.a;
            dig_reg[1] <= chain_next.b;
            dig_reg[2] <= chain_next.c;
            dig_reg[3] <= chain_next.d;
        end
        else if (out_xfer)
        begin
            for (int k = 0; k < DIGEST_WORDS - 1; k++)
            begin
                dig_reg[k] <= dig_reg[k + 1];
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign digest_word      = dig_reg[0];
    assign digest_index     = didx_reg;
    assign last_digest_word = (didx_reg == DIDX_W'(DIGEST_WORDS - 1));

`ifndef SYNTHESIS
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (rnd_reg < RND_W'(ROUNDS)))
        else $error("round counter out of range");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (wr_addr == WADDR_W'(BLOCK_WORDS - 1))) |=> (state_reg == ST_COMP))
        else $error("compression did not start after the sixteenth word");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && (didx_reg != '0)) |=> !$rose(out_valid_reg)
            && $stable(didx_reg))
        else $error("digest overwritten while draining");

    a_comp_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> !in_ready)
        else $error("buffer writable during compression");
`endif

endmodule

### tb/tb_md4_block_hash_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_md4_block_hash_unit
// Feeds message words to the md4 block hash unit under several idle
// and stall mixes. Each word transfer updates an in-bench md4 model, which
// queues the digest words. Each digest transfer is checked against the
// oldest queued word.
// ----------------------------------------------------------------------------
module tb_md4_block_hash_unit;
    import md4bh_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int ITEM_TARGET   = 180;
    localparam int PHASES        = 4;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [DIDX_W-1:0] index;
        logic              last;
    } digest_item_t;

    class md4_scoreboard;
        logic [WORD_W-1:0] chain [DIGEST_WORDS];
        logic [WORD_W-1:0] block_words [BLOCK_WORDS];
        int unsigned       fill;
        digest_item_t      digest_queue [$];
        int unsigned       errors;

        function new();
            load_iv();
            foreach (block_words[n])
                block_words[n] = '0;
            fill   = 0;
            errors = 0;
        endfunction

        function void load_iv();
            chain[0] = IV_A;
            chain[1] = IV_B;
            chain[2] = IV_C;
            chain[3] = IV_D;
        endfunction

        function logic [WORD_W-1:0] rot_left(logic [WORD_W-1:0] x, int unsigned s);
            return (x << s) | (x >> (WORD_W - s));
        endfunction

        function int unsigned shift_amount(logic [1:0] grp, int unsigned j);
            int unsigned s;
            case (grp)
                GRP_F:
                begin
                    case (j)
                        0:       s = 3;
                        1:       s = 7;
                        2:       s = 11;
                        default: s = 19;
                    endcase
                end
                GRP_G:
                begin
                    case (j)
                        0:       s = 3;
                        1:       s = 5;
                        2:       s = 9;
                        default: s = 13;
                    endcase
                end
                default:
                begin
                    case (j)
                        0:       s = 3;
                        1:       s = 9;
                        2:       s = 11;
                        default: s = 15;
                    endcase
                end
            endcase
            return s;
        endfunction

        // 48 rounds over the buffered block, folded into the chaining values
        function void compress_block();
            logic [WORD_W-1:0] v [DIGEST_WORDS];
            logic [WORD_W-1:0] b, c, d, f, k;
            logic [1:0]        grp;
            int unsigned       t, slot;
            v = chain;
            for (int r = 0; r < 3; r++)
            begin
                grp = 2'(r);
                for (int i = 0; i < BLOCK_WORDS; i++)
                begin
                    // target walks a, d, c, b
                    t = (4 - (i % 4)) % 4;
                    b = v[(t + 1) % 4];
                    c = v[(t + 2) % 4];
                    d = v[(t + 3) % 4];
                    case (grp)
                        GRP_F:
                        begin
                            f    = (b & c) | (~b & d);
                            slot = i;
                            k    = '0;
                        end
                        GRP_G:
                        begin
                            f    = (b & c) | (b & d) | (c & d);
                            slot = (i % 4) * 4 + i / 4;
                            k    = K_TWO;
                        end
                        default:
                        begin
                            f    = b ^ c ^ d;
                            // bit-reversed word order
                            slot = {i[0], i[1], i[2], i[3]};
                            k    = K_THREE;
                        end
                    endcase
                    v[t] = rot_left(v[t] + f + block_words[slot] + k, shift_amount(grp, i % 4));
                end
            end
            foreach (chain[n])
                chain[n] = chain[n] + v[n];
        endfunction

        function void note_word(logic [WORD_W-1:0] word, logic start, logic last_blk);
            digest_item_t item;
            if (start)
            begin
                load_iv();
                fill = 0;
            end
            block_words[fill] = word;
            fill = (fill + 1) % BLOCK_WORDS;
            if (fill != 0)
                return;
            compress_block();
            if (!last_blk)
                return;
            for (int n = 0; n < DIGEST_WORDS; n++)
            begin
                item.word    = chain[n];
                item.index   = DIDX_W'(n);
                item.last    = (n == DIGEST_WORDS - 1);
                digest_queue = {digest_queue, item};
            end
        endfunction

        function void check_digest(logic [WORD_W-1:0] word, logic [DIDX_W-1:0] index,
                                   logic last);
            digest_item_t want;
            if (digest_queue.size() == 0)
            begin
                $error("digest transfer with none expected: word %h index %0d", word, index);
                errors++;
                return;
            end
            want = digest_queue.pop_front();
            if (word !== want.word)
            begin
                $error("digest_word mismatch: expected %h, actual %h", want.word, word);
                errors++;
            end
            if (index !== want.index)
            begin
                $error("digest_index mismatch: expected %0d, actual %0d", want.index, index);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_digest_word mismatch: expected %b, actual %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              in_valid      = 1'b0;
    logic              in_ready;
    logic [WORD_W-1:0] message_word  = '0;
    logic              start_message = 1'b0;
    logic              final_block   = 1'b0;
    logic              out_valid;
    logic              out_ready     = 1'b0;
    logic [WORD_W-1:0] digest_word;
    logic [DIDX_W-1:0] digest_index;
    logic              last_digest_word;

    int unsigned   sender_idle_pct = 0;
    int unsigned   stall_pct       = 0;
    int unsigned   words_sent      = 0;
    int unsigned   quiet_cycles    = 0;
    md4_scoreboard sb;

    md4_block_hash_unit DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .message_word     (message_word),
        .start_message    (start_message),
        .final_block      (final_block),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .digest_word      (digest_word),
        .digest_index     (digest_index),
        .last_digest_word (last_digest_word)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_word(message_word, start_message, final_block);
            if (out_valid && out_ready)
                sb.check_digest(digest_word, digest_index, last_digest_word);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return {WORD_W{1'b0}};
        if (sel == 1)
            return {WORD_W{1'b1}};
        return $urandom;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word, input logic first,
                             input logic last_blk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        message_word  <= word;
        start_message <= first;
        final_block   <= last_blk;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // final flag is random on all but the sixteenth word, where only it counts
    task automatic send_block(input logic with_start, input logic last_blk);
        for (int n = 0; n < BLOCK_WORDS; n++)
            send_word(pick_word(), with_start && (n == 0),
                      (n == BLOCK_WORDS - 1) ? last_blk : 1'($urandom_range(0, 1)));
    endtask

    task automatic send_message();
        int unsigned kind, blocks, cut;
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            blocks = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
            for (int n = 0; n < blocks; n++)
                send_block(n == 0, n == blocks - 1);
        end
        else if (kind < 87)
            send_block(1'b0, 1'b1);   // keeps hashing from the previous chaining values
        else
        begin
            // truncated message, dropped by whatever start comes next
            cut = $urandom_range(1, BLOCK_WORDS - 1);
            for (int n = 0; n < cut; n++)
                send_word(pick_word(), (n == 0) && 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
        end
    endtask

    task automatic drain_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.digest_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned phase_end;
        sb = new();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one block of all-zero and all-one words, final flag on every word
        for (int n = 0; n < BLOCK_WORDS; n++)
            send_word(n[0] ? {WORD_W{1'b1}} : {WORD_W{1'b0}}, n == 0, 1'b1);
        drain_digests();
        // words after the digest without start, then a start in mid-block
        for (int n = 0; n < 5; n++)
            send_word(pick_word(), n == 4, 1'b0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1:
                begin
                    sender_idle_pct = 65;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 65;
                end
                default:
                begin
                    sender_idle_pct = 9;
                    stall_pct       = 9;
                end
            endcase
            phase_end = ITEM_TARGET * (ph + 1) / PHASES;
            while (words_sent < phase_end)
                send_message();
            drain_digests();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.digest_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
